// File: design/align_steering_unit_defines.svh
// Assertion helpers, used by align_steering_unit.sv to check its own logic.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef ALIGN_STEERING_UNIT_DEFINES_SVH
`define ALIGN_STEERING_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define ASU_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define ASU_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/asu_pkg.sv
package asu_pkg;

  // Angles are in units of 2^-ANGLE_FRAC_BITS degree.
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int HALF_TURN       = 180 << ANGLE_FRAC_BITS;
  localparam int FULL_TURN       = 2 * HALF_TURN;
  localparam int SCALE_MS        = 1000;

  // Field and register widths.
  localparam int ANGLE_W     = 15;
  localparam int RATE_W      = 21;
  localparam int ACCEL_W     = 24;
  localparam int BAND_W      = 14;
  localparam int TIME_W      = 16;
  localparam int MAX_RATE_W  = 20;
  localparam int MAX_ACCEL_W = 23;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 23;

  // Internal widths.
  localparam int WRAP_W  = ANGLE_W + 2;            // difference plus half turn
  localparam int PROD1_W = MAX_RATE_W + BAND_W;    // max rate times size
  localparam int DIFF_W  = RATE_W + 1;             // target rate minus current rate
  localparam int PROD2_W = 32;                     // rate difference times 1000
  localparam int MAG2_W  = PROD2_W - 1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SLOWING_BAND   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_REACH_TIME     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN_RATE  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN_ACCEL = CFG_IDX_W'(4);

  // Register reset values.
  localparam logic [BAND_W-1:0]      RST_DEAD_BAND      = BAND_W'(64);
  localparam logic [BAND_W-1:0]      RST_SLOWING_BAND   = BAND_W'(128);
  localparam logic [TIME_W-1:0]      RST_REACH_TIME     = TIME_W'(100);
  localparam logic [MAX_RATE_W-1:0]  RST_MAX_TURN_RATE  = MAX_RATE_W'(11520);
  localparam logic [MAX_ACCEL_W-1:0] RST_MAX_TURN_ACCEL = MAX_ACCEL_W'(64000);

  // Side information carried through the turn rate divider.
  typedef struct packed {
    logic                     on_target;
    logic                     zero;
    logic                     full;
    logic                     neg;
    logic signed [RATE_W-1:0] rate;
  } asu_side1_t;

  // Side information carried through the time scale divider.
  typedef struct packed {
    logic on_target;
    logic neg;
  } asu_side2_t;

endpackage

// File: design/asu_channels_if.sv
interface asu_in_if;
  import asu_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] target_angle;
  logic signed [ANGLE_W-1:0] current_angle;
  logic signed [RATE_W-1:0]  current_turn_rate;

  modport source (output valid, output target_angle, output current_angle,
                  output current_turn_rate, input ready);
  modport sink   (input valid, input target_angle, input current_angle,
                  input current_turn_rate, output ready);
endinterface

interface asu_out_if;
  import asu_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ACCEL_W-1:0] steer_accel;
  logic                      within_target;

  modport source (output valid, output steer_accel, output within_target,
                  input ready);
  modport sink   (input valid, input steer_accel, input within_target,
                  output ready);
endinterface

// File: design/asu_div_pipe.sv
module asu_div_pipe #(
  parameter int Q_W    = 20,
  parameter int D_W    = 14,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [D_W-1:0]    in_rem,
  input  logic [Q_W-1:0]    in_num,
  input  logic [SIDE_W-1:0] in_side,
  input  logic [D_W-1:0]    dvs,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_quot,
  output logic [SIDE_W-1:0] out_side
);

  // Restoring division, one quotient bit per stage. The dividend bits are
  // shifted out of num_r from the top while quotient bits enter at the bottom.
  // The starting remainder must be below the divisor.
  logic [Q_W-1:0]    vld_r;
  logic [D_W-1:0]    rem_r  [Q_W];
  logic [Q_W-1:0]    num_r  [Q_W];
  logic [SIDE_W-1:0] side_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic              vld_in;
    logic [D_W-1:0]    rem_in;
    logic [Q_W-1:0]    num_in;
    logic [SIDE_W-1:0] side_in;
    logic [D_W:0]      trial;
    logic [D_W:0]      diff;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = in_rem;
      assign num_in  = in_num;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign num_in  = num_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign trial = {rem_in, num_in[Q_W-1]};
    assign diff  = trial - {1'b0, dvs};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    // A borrow out of the top bit means the divisor did not fit.
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= diff[D_W] ? trial[D_W-1:0] : diff[D_W-1:0];
        num_r[k]  <= {num_in[Q_W-2:0], ~diff[D_W]};
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[Q_W-1];
  assign out_quot  = num_r[Q_W-1];
  assign out_side  = side_r[Q_W-1];

endmodule

// File: design/align_steering_unit.sv
// Angular steering toward a target orientation. Each item carries the target
// and current orientation and the current turn rate; each yields exactly one
// result with the clamped angular acceleration and a within_target flag. The
// unit takes one item per clock while ready is high, that is while the skid
// register is empty. The pipeline is built from two pipelined restoring
// dividers, one quotient bit per stage: 20 stages for the proportional turn
// rate inside the slowing band and 31 stages for the scaling by
// 1000 / (reach time in ms), plus nine stages of wrap, multiply, select and
// clamp. A skid register at the output lets the pipeline fill one more item
// while a result waits; ready drops only while the skid register is full.
// Configuration registers are written on cfg_we and apply to all items in
// flight, so they should be changed only while the unit is empty.
`include "align_steering_unit_defines.svh"

module align_steering_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  asu_in_if.sink                         in_chan,
  asu_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [asu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import asu_pkg::*;

  // Configuration registers.
  logic [BAND_W-1:0]      dead_band_r;
  logic [BAND_W-1:0]      slowing_band_r;
  logic [TIME_W-1:0]      reach_time_r;
  logic [MAX_RATE_W-1:0]  max_turn_rate_r;
  logic [MAX_ACCEL_W-1:0] max_turn_accel_r;
  logic [TIME_W-1:0]      time_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_band_r      <= RST_DEAD_BAND;
      slowing_band_r   <= RST_SLOWING_BAND;
      reach_time_r     <= RST_REACH_TIME;
      max_turn_rate_r  <= RST_MAX_TURN_RATE;
      max_turn_accel_r <= RST_MAX_TURN_ACCEL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEAD_BAND:      dead_band_r      <= cfg_data[BAND_W-1:0];
        REG_SLOWING_BAND:   slowing_band_r   <= cfg_data[BAND_W-1:0];
        REG_REACH_TIME:     reach_time_r     <= cfg_data[TIME_W-1:0];
        REG_MAX_TURN_RATE:  max_turn_rate_r  <= cfg_data[MAX_RATE_W-1:0];
        REG_MAX_TURN_ACCEL: max_turn_accel_r <= cfg_data[MAX_ACCEL_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero time to reach behaves as one millisecond.
  assign time_eff = (reach_time_r == '0) ? TIME_W'(1) : reach_time_r;

  // Pipeline advance: the whole pipeline moves unless the skid register holds an item.
  logic en;
  logic skid_valid_r;

  assign en            = !skid_valid_r;
  assign in_chan.ready = en;

  // Stage a: difference plus half turn.
  logic                     a_valid_r;
  logic signed [WRAP_W-1:0] a_sum_r;
  logic signed [WRAP_W-1:0] a_sum_nxt;
  logic signed [RATE_W-1:0] a_rate_r;

  assign a_sum_nxt = WRAP_W'(in_chan.target_angle) - WRAP_W'(in_chan.current_angle)
                   + WRAP_W'(HALF_TURN);

  // Stage b: wrap into the half-turn range.
  logic                      b_valid_r;
  logic signed [ANGLE_W-1:0] b_d_r;
  logic signed [ANGLE_W-1:0] b_d_nxt;
  logic signed [RATE_W-1:0]  b_rate_r;
  logic signed [WRAP_W-1:0]  b_mod;

  always_comb begin
    if (a_sum_r < 0) begin
      b_mod = a_sum_r + WRAP_W'(FULL_TURN);
    end else if (a_sum_r >= FULL_TURN) begin
      b_mod = a_sum_r - WRAP_W'(FULL_TURN);
    end else begin
      b_mod = a_sum_r;
    end
    b_d_nxt = ANGLE_W'(b_mod - WRAP_W'(HALF_TURN));
  end

  // Stage c: size and sign of the difference.
  logic                     c_valid_r;
  logic [BAND_W-1:0]        c_size_r;
  logic [BAND_W-1:0]        c_size_nxt;
  logic                     c_neg_r;
  logic signed [RATE_W-1:0] c_rate_r;

  assign c_size_nxt = BAND_W'(b_d_r[ANGLE_W-1] ? -b_d_r : b_d_r);

  // Stage e: band tests and the proportional rate product.
  logic               e_valid_r;
  logic [PROD1_W-1:0] e_prod_r;
  logic [PROD1_W-1:0] e_prod_nxt;
  asu_side1_t         e_side_r;
  asu_side1_t         e_side_nxt;

  assign e_prod_nxt           = PROD1_W'(max_turn_rate_r) * PROD1_W'(c_size_r);
  assign e_side_nxt.on_target = c_size_r < dead_band_r;
  assign e_side_nxt.zero      = c_size_r == '0;
  assign e_side_nxt.full      = c_size_r > slowing_band_r;
  assign e_side_nxt.neg       = c_neg_r;
  assign e_side_nxt.rate      = c_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_chan.valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      e_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sum_r  <= a_sum_nxt;
      a_rate_r <= in_chan.current_turn_rate;
      b_d_r    <= b_d_nxt;
      b_rate_r <= a_rate_r;
      c_size_r <= c_size_nxt;
      c_neg_r  <= b_d_r[ANGLE_W-1];
      c_rate_r <= b_rate_r;
      e_prod_r <= e_prod_nxt;
      e_side_r <= e_side_nxt;
    end
  end

  // Proportional rate: max_turn_rate * size / slowing_band. Inside the band
  // the quotient fits in the max rate width, so only that many steps are needed.
  logic                  d1_valid;
  logic [MAX_RATE_W-1:0] d1_quot;
  asu_side1_t            d1_side;

  asu_div_pipe #(
    .Q_W    (MAX_RATE_W),
    .D_W    (BAND_W),
    .SIDE_W ($bits(asu_side1_t))
  ) u_rate_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (e_valid_r),
    .in_rem    (e_prod_r[PROD1_W-1 -: BAND_W]),
    .in_num    (e_prod_r[MAX_RATE_W-1:0]),
    .in_side   (e_side_r),
    .dvs       (slowing_band_r),
    .out_valid (d1_valid),
    .out_quot  (d1_quot),
    .out_side  (d1_side)
  );

  // Stage f: target rate magnitude.
  logic                  f_valid_r;
  logic [MAX_RATE_W-1:0] f_smag_r;
  logic [MAX_RATE_W-1:0] f_smag_nxt;
  asu_side1_t            f_side_r;

  always_comb begin
    if (d1_side.zero) begin
      f_smag_nxt = '0;
    end else if (d1_side.full) begin
      f_smag_nxt = max_turn_rate_r;
    end else begin
      f_smag_nxt = d1_quot;
    end
  end

  // Stage g: signed target rate minus current rate.
  logic                     g_valid_r;
  logic signed [DIFF_W-1:0] g_diff_r;
  logic signed [DIFF_W-1:0] g_diff_nxt;
  logic signed [DIFF_W-1:0] g_speed;
  logic                     g_within_r;

  always_comb begin
    g_speed = $signed({2'b00, f_smag_r});
    if (f_side_r.neg) begin
      g_speed = -g_speed;
    end
    g_diff_nxt = g_speed - DIFF_W'(f_side_r.rate);
  end

  // Stage h: scale to milliseconds.
  logic                      h_valid_r;
  logic signed [PROD2_W-1:0] h_prod_r;
  logic signed [PROD2_W-1:0] h_prod_nxt;
  logic                      h_within_r;

  assign h_prod_nxt = PROD2_W'(g_diff_r) * PROD2_W'(SCALE_MS);

  // Stage i: magnitude for the unsigned divider.
  logic              i_valid_r;
  logic [MAG2_W-1:0] i_mag_r;
  logic [MAG2_W-1:0] i_mag_nxt;
  asu_side2_t        i_side_r;

  assign i_mag_nxt = MAG2_W'(h_prod_r[PROD2_W-1] ? -h_prod_r : h_prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
      g_valid_r <= 1'b0;
      h_valid_r <= 1'b0;
      i_valid_r <= 1'b0;
    end else if (en) begin
      f_valid_r <= d1_valid;
      g_valid_r <= f_valid_r;
      h_valid_r <= g_valid_r;
      i_valid_r <= h_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_smag_r           <= f_smag_nxt;
      f_side_r           <= d1_side;
      g_diff_r           <= g_diff_nxt;
      g_within_r         <= f_side_r.on_target;
      h_prod_r           <= h_prod_nxt;
      h_within_r         <= g_within_r;
      i_mag_r            <= i_mag_nxt;
      i_side_r.on_target <= h_within_r;
      i_side_r.neg       <= h_prod_r[PROD2_W-1];
    end
  end

  // Division by the effective time to reach, truncating toward zero.
  logic              d2_valid;
  logic [MAG2_W-1:0] d2_quot;
  asu_side2_t        d2_side;

  asu_div_pipe #(
    .Q_W    (MAG2_W),
    .D_W    (TIME_W),
    .SIDE_W ($bits(asu_side2_t))
  ) u_time_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (i_valid_r),
    .in_rem    ('0),
    .in_num    (i_mag_r),
    .in_side   (i_side_r),
    .dvs       (time_eff),
    .out_valid (d2_valid),
    .out_quot  (d2_quot),
    .out_side  (d2_side)
  );

  // Clamp, restore the sign and force zero inside the dead band.
  logic [MAX_ACCEL_W-1:0]    res_mag;
  logic signed [ACCEL_W-1:0] res_accel_nxt;

  always_comb begin
    if (d2_quot > MAG2_W'(max_turn_accel_r)) begin
      res_mag = max_turn_accel_r;
    end else begin
      res_mag = d2_quot[MAX_ACCEL_W-1:0];
    end
    res_accel_nxt = $signed({1'b0, res_mag});
    if (d2_side.neg) begin
      res_accel_nxt = -res_accel_nxt;
    end
    if (d2_side.on_target) begin
      res_accel_nxt = '0;
    end
  end

  // Output register with skid register.
  logic                      out_valid_r;
  logic signed [ACCEL_W-1:0] out_accel_r;
  logic                      out_within_r;
  logic signed [ACCEL_W-1:0] skid_accel_r;
  logic                      skid_within_r;
  logic                      out_take;

  assign out_take = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r  <= skid_valid_r || d2_valid;
      skid_valid_r <= 1'b0;
    end else if (d2_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_accel_r  <= skid_valid_r ? skid_accel_r  : res_accel_nxt;
      out_within_r <= skid_valid_r ? skid_within_r : d2_side.on_target;
    end else if (en) begin
      skid_accel_r  <= res_accel_nxt;
      skid_within_r <= d2_side.on_target;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.steer_accel   = out_accel_r;
  assign out_chan.within_target = out_within_r;

  `ASU_CHECK(skid_implies_out, skid_valid_r |-> out_valid_r, "skid full while output empty")
  `ASU_CHECK_NEXT(stall_fills_skid, out_valid_r && !out_chan.ready && !skid_valid_r && d2_valid, skid_valid_r, "stalled item not caught by skid register")
  `ASU_CHECK(within_gives_zero, out_valid_r && out_within_r |-> out_accel_r == '0, "nonzero acceleration inside dead band")
  `ASU_CHECK(accel_clamped, out_valid_r |-> (out_accel_r <= $signed({1'b0, max_turn_accel_r})) && (out_accel_r >= -$signed({1'b0, max_turn_accel_r})), "acceleration exceeds limit")

endmodule

// File: tb/align_steering_unit_tb.sv
`timescale 1ns / 1ps

module align_steering_unit_tb;
  import asu_pkg::*;

  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int DRAIN_CYCLES    = 80;
  localparam int NUM_PROBES      = 20;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] accel;
    logic                      on_target;
  } steer_result_t;

  // One directed item. When typed is set, accel and on_target are the known answer.
  typedef struct packed {
    int tgt;
    int cur;
    int rate;
    bit typed;
    int accel;
    bit on_target;
  } probe_t;

  localparam probe_t PROBES [NUM_PROBES] = '{
    '{0, 0, 0, 1'b1, 0, 1'b1},
    '{100, 50, 0, 1'b1, 0, 1'b1},
    '{11519, -11520, 0, 1'b1, 0, 1'b1},
    '{-11520, 11519, 0, 1'b1, 0, 1'b1},
    '{63, 0, 0, 1'b1, 0, 1'b1},
    '{0, -11520, 0, 1'b1, -64000, 1'b0},
    '{0, 11519, 0, 1'b1, -64000, 1'b0},
    '{5000, 0, 1048575, 1'b1, -64000, 1'b0},
    '{5000, 0, -1048576, 1'b1, 64000, 1'b0},
    '{0, 0, -1048576, 1'b1, 0, 1'b1},
    '{64, 0, 0, 1'b0, 0, 1'b0},
    '{128, 0, 0, 1'b0, 0, 1'b0},
    '{129, 0, 0, 1'b0, 0, 1'b0},
    '{100, 0, 5000, 1'b0, 0, 1'b0},
    '{-100, 0, -3000, 1'b0, 0, 1'b0},
    '{-16384, 16383, 0, 1'b0, 0, 1'b0},
    '{16383, -16384, 77, 1'b0, 0, 1'b0},
    '{200, -200, 11520, 1'b1, 0, 1'b0},
    '{-300, 0, -12000, 1'b0, 0, 1'b0},
    '{11519, 11519, 1048575, 1'b1, 0, 1'b1}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  asu_in_if  in_chan ();
  asu_out_if out_chan ();

  align_steering_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Register contents as the unit should hold them.
  logic [BAND_W-1:0]      dead_band;
  logic [BAND_W-1:0]      slowing_band;
  logic [TIME_W-1:0]      reach_time;
  logic [MAX_RATE_W-1:0]  max_turn_rate;
  logic [MAX_ACCEL_W-1:0] max_turn_accel;

  steer_result_t pending_results [$];
  bit            mismatch_seen = 1'b0;
  // 0: both sides idle at random, 1: no idling, 2: sender never idles,
  // 3: receiver never stalls.
  int            idle_mode = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic steer_result_t predict_steer(input logic signed [ANGLE_W-1:0] tgt,
                                                  input logic signed [ANGLE_W-1:0] cur,
                                                  input logic signed [RATE_W-1:0]  rate);
    longint        wrapped;
    longint        diff;
    longint        size;
    longint        speed;
    longint        t;
    longint        accel;
    steer_result_t res;
    wrapped = (longint'(tgt) - longint'(cur) + HALF_TURN) % FULL_TURN;
    if (wrapped < 0) wrapped += FULL_TURN;
    diff = wrapped - HALF_TURN;
    size = (diff < 0) ? -diff : diff;
    if (size < longint'(dead_band)) begin
      res.accel     = '0;
      res.on_target = 1'b1;
    end else begin
      if (size == 0) speed = 0;
      else if (size > longint'(slowing_band)) speed = longint'(max_turn_rate);
      else speed = longint'(max_turn_rate) * size / longint'(slowing_band);
      if (diff < 0) speed = -speed;
      // A zero time to reach is taken as one millisecond.
      t = (reach_time == '0) ? 1 : longint'(reach_time);
      accel = (speed - longint'(rate)) * SCALE_MS / t;
      if (accel > longint'(max_turn_accel)) accel = longint'(max_turn_accel);
      else if (accel < -longint'(max_turn_accel)) accel = -longint'(max_turn_accel);
      res.accel     = ACCEL_W'(accel);
      res.on_target = 1'b0;
    end
    return res;
  endfunction

  function automatic int draw_gap(input bit sender);
    if (idle_mode == 1 || (idle_mode == 2 && sender) || (idle_mode == 3 && !sender))
      return 0;
    return $urandom_range(0, 12);
  endfunction

  task automatic drive_item(input int tgt, input int cur, input int rate,
                            input bit typed, input steer_result_t typed_res);
    int gap;
    gap = draw_gap(1'b1);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid             <= 1'b1;
    in_chan.target_angle      <= ANGLE_W'(tgt);
    in_chan.current_angle     <= ANGLE_W'(cur);
    in_chan.current_turn_rate <= RATE_W'(rate);
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    if (typed) pending_results.push_back(typed_res);
    else pending_results.push_back(predict_steer(ANGLE_W'(tgt), ANGLE_W'(cur), RATE_W'(rate)));
  endtask

  // Most items are in range; some sit right at a band edge, some are equal
  // angles and some use the full field width.
  task automatic drive_random_item();
    int tgt;
    int cur;
    int rate;
    int d;
    cur = $urandom_range(0, FULL_TURN - 1) - HALF_TURN;
    case ($urandom_range(0, 9))
      0: tgt = cur;
      1, 2: begin
        d = ($urandom_range(0, 1) ? int'(dead_band) : int'(slowing_band))
            + $urandom_range(0, 4) - 2;
        if ($urandom_range(0, 1)) d = -d;
        tgt = cur + d;
        if (tgt > HALF_TURN - 1) tgt -= FULL_TURN;
        else if (tgt < -HALF_TURN) tgt += FULL_TURN;
      end
      3: begin
        tgt = $urandom();
        cur = $urandom();
      end
      default: tgt = $urandom_range(0, FULL_TURN - 1) - HALF_TURN;
    endcase
    rate = $urandom_range(0, 2) ? $urandom_range(0, 40000) - 20000 : $urandom();
    drive_item(tgt, cur, rate, 1'b0, '0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  task automatic load_settings(input int db, input int sb, input int ttr,
                               input int mr, input int ma);
    write_reg(REG_DEAD_BAND, db);
    write_reg(REG_SLOWING_BAND, sb);
    write_reg(REG_REACH_TIME, ttr);
    write_reg(REG_MAX_TURN_RATE, mr);
    write_reg(REG_MAX_TURN_ACCEL, ma);
    cfg_we         <= 1'b0;
    dead_band      = BAND_W'(db);
    slowing_band   = BAND_W'(sb);
    reach_time     = TIME_W'(ttr);
    max_turn_rate  = MAX_RATE_W'(mr);
    max_turn_accel = MAX_ACCEL_W'(ma);
  endtask

  initial begin
    int            phase;
    int            i;
    int            n;
    steer_result_t typed_res;
    rst_n                     <= 1'b0;
    cfg_we                    <= 1'b0;
    cfg_index                 <= '0;
    cfg_data                  <= '0;
    in_chan.valid             <= 1'b0;
    in_chan.target_angle      <= '0;
    in_chan.current_angle     <= '0;
    in_chan.current_turn_rate <= '0;
    dead_band      = RST_DEAD_BAND;
    slowing_band   = RST_SLOWING_BAND;
    reach_time     = RST_REACH_TIME;
    max_turn_rate  = RST_MAX_TURN_RATE;
    max_turn_accel = RST_MAX_TURN_ACCEL;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      idle_mode = phase % 4;
      case (phase)
        0: ;
        1: load_settings(0, 0, 0, 0, 0);
        2: load_settings((1 << BAND_W) - 1, (1 << BAND_W) - 1, (1 << TIME_W) - 1,
                         (1 << MAX_RATE_W) - 1, (1 << MAX_ACCEL_W) - 1);
        3: load_settings(0, FULL_TURN / 2, 1, (1 << MAX_RATE_W) - 1,
                         (1 << MAX_ACCEL_W) - 1);
        4: load_settings(FULL_TURN / 2, 0, (1 << TIME_W) - 1, 0, 1);
        default: load_settings(
          $urandom_range(0, 3) ? $urandom_range(0, 400) : $urandom_range(0, (1 << BAND_W) - 1),
          $urandom_range(0, 3) ? $urandom_range(0, 2000) : $urandom_range(0, (1 << BAND_W) - 1),
          $urandom_range(0, 3) ? $urandom_range(1, 1000) : $urandom_range(0, (1 << TIME_W) - 1),
          $urandom_range(0, (1 << MAX_RATE_W) - 1),
          $urandom_range(0, (1 << MAX_ACCEL_W) - 1));
      endcase

      n = ITEMS_PER_PHASE;
      if (phase == 0) begin
        for (i = 0; i < NUM_PROBES; i++) begin
          typed_res.accel     = ACCEL_W'(PROBES[i].accel);
          typed_res.on_target = PROBES[i].on_target;
          drive_item(PROBES[i].tgt, PROBES[i].cur, PROBES[i].rate, PROBES[i].typed, typed_res);
        end
        n -= NUM_PROBES;
      end
      repeat (n) drive_random_item();
      in_chan.valid <= 1'b0;
      // Every item yields a result, so an empty queue means an empty pipeline.
      while (pending_results.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!mismatch_seen) begin
      $display("PASS align_steering_unit");
    end else begin
      $display("FAIL align_steering_unit");
    end
    $finish;
  end

  initial begin
    int            gap;
    steer_result_t want;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = draw_gap(1'b0);
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        $error("unexpected result: steer_accel %0d within_target %0b",
               out_chan.steer_accel, out_chan.within_target);
        mismatch_seen = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (out_chan.steer_accel !== want.accel) begin
          $error("steer_accel: expected %0d, actual %0d", want.accel, out_chan.steer_accel);
          mismatch_seen = 1'b1;
        end
        if (out_chan.within_target !== want.on_target) begin
          $error("within_target: expected %0b, actual %0b", want.on_target,
                 out_chan.within_target);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("FAIL align_steering_unit");
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/asu_pkg.sv
design/asu_channels_if.sv
design/asu_div_pipe.sv
design/align_steering_unit.sv
tb/align_steering_unit_tb.sv
